### rtl/scpq_pkg.sv
// Package for the sorted cost priority queue: sizes, codes, item and control types.
`default_nettype none

package scpq_pkg;

	// Storage and field sizes.
	localparam int CAPACITY  = 64;
	localparam int COST_BITS = 32;
	localparam int ID_BITS   = 16;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int IDX_W     = $clog2(CAPACITY);

	// Operation codes of an input item.
	typedef enum logic [1:0] {
		FN_PUSH     = 2'd0,
		FN_POP      = 2'd1,
		FN_CONTAINS = 2'd2,
		FN_REMOVE   = 2'd3
	} func_t;

	// Status codes of a result item.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// One input item.
	typedef struct packed {
		func_t                func;
		logic [COST_BITS-1:0] node_cost;
		logic [ID_BITS-1:0]   node_id;
	} req_item_t;

	// One result item.
	typedef struct packed {
		status_t              status;
		logic                 found;
		logic [COST_BITS-1:0] top_cost;
		logic [ID_BITS-1:0]   top_id;
		logic [CNT_W-1:0]     entry_count_out;
		logic                 is_empty;
	} rsp_item_t;

	// One stored queue entry.
	typedef struct packed {
		logic [COST_BITS-1:0] cost;
		logic [ID_BITS-1:0]   id;
	} entry_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_COMPARE,
		S_SEARCH,
		S_UPDATE,
		S_RESULT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic compare;
		logic step;
		logic update;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic search_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

### rtl/scpq_ctrl.sv
// Controller state machine of the sorted cost priority queue.
`default_nettype none

module scpq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire scpq_pkg::sts_t sts,
	output scpq_pkg::cmd_t     cmd
);
	import scpq_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nx;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state: one item goes through compare, search, update and result.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nx = S_COMPARE;
				end
			end
			S_COMPARE: begin
				state_nx = S_SEARCH;
			end
			S_SEARCH: begin
				if (sts.search_done) begin
					state_nx = S_UPDATE;
				end
			end
			S_UPDATE: begin
				state_nx = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// Commands and the input stall follow the current state.
	always_comb begin
		cmd         = '0;
		req_stall   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = req_valid;
			end
			S_COMPARE: begin
				cmd.compare = 1'b1;
			end
			S_SEARCH: begin
				cmd.step = !sts.search_done;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
			end
			S_RESULT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// An item that is taken always moves on to the compare state.
	a_load_to_compare: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_COMPARE)
		else $error("accepted item did not enter compare");

	// A result that is emitted returns the controller to idle.
	a_emit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == S_IDLE)
		else $error("controller did not return to idle after a result");

endmodule

`default_nettype wire

### rtl/scpq_dp.sv
// Datapath of the sorted cost priority queue: entry row, compare flags, search and result register.
`default_nettype none

module scpq_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire scpq_pkg::req_item_t req,
	input  wire scpq_pkg::cmd_t      cmd,
	output scpq_pkg::sts_t           sts,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output scpq_pkg::rsp_item_t      rsp
);
	import scpq_pkg::*;

	// Latched item.
	func_t                func_q;
	logic [COST_BITS-1:0] cost_q;
	logic [ID_BITS-1:0]   id_q;

	// Entry row and fill count.
	entry_t               entries_q [CAPACITY];
	logic [CNT_W-1:0]     count_q;

	// Per-entry compare flags, registered once per item.
	logic [CAPACITY-1:0]  lt_c, eq_c, idm_c;
	logic [CAPACITY-1:0]  lt_q, eq_q, idm_q;

	// Search state.
	logic [CNT_W-1:0]     lo_q, hi_q, pos_q;
	logic                 done_q;
	logic [CNT_W:0]       sum;
	logic [CNT_W-1:0]     mid;
	logic [CNT_W-1:0]     span;
	logic [IDX_W-1:0]     mid_idx, lo_idx, pos_idx;

	// Update decisions.
	logic                 full;
	logic                 match;
	logic                 do_ins;
	logic                 do_drop;
	logic [CNT_W-1:0]     drop_pos;
	status_t              status_c;
	status_t              status_q;
	logic                 found_q;

	// Result register.
	logic                 rsp_valid_q;
	rsp_item_t            rsp_q;

	// Latch the accepted item.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= req.func;
			cost_q <= req.node_cost;
			id_q   <= req.node_id;
		end
	end

	// One comparator per entry against the latched cost and id.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
		assign lt_c[i]  = entries_q[i].cost < cost_q;
		assign eq_c[i]  = entries_q[i].cost == cost_q;
		assign idm_c[i] = entries_q[i].id == id_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			lt_q  <= lt_c;
			eq_q  <= eq_c;
			idm_q <= idm_c;
		end
	end

	// Bisection step on the registered flags.
	assign sum     = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = sum[CNT_W:1];
	assign span    = hi_q - lo_q;
	assign mid_idx = mid[IDX_W-1:0];
	assign lo_idx  = lo_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (cmd.compare) begin
			done_q <= 1'b0;
		end else if (cmd.step) begin
			done_q <= (lo_q == hi_q) || (span == CNT_W'(1)) || eq_q[mid_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			lo_q <= '0;
			hi_q <= count_q;
		end else if (cmd.step) begin
			priority if (lo_q == hi_q) begin
				pos_q <= lo_q;
			end else if (span == CNT_W'(1)) begin
				pos_q <= lt_q[lo_idx] ? hi_q : lo_q;
			end else if (eq_q[mid_idx]) begin
				pos_q <= mid;
			end else if (lt_q[mid_idx]) begin
				lo_q <= mid;
			end else begin
				hi_q <= mid;
			end
		end
	end

	// Decide what the update does and which status it reports.
	assign pos_idx  = pos_q[IDX_W-1:0];
	assign full     = count_q == CNT_W'(CAPACITY);
	assign match    = (pos_q < count_q) && eq_q[pos_idx] && idm_q[pos_idx];
	assign do_ins   = (func_q == FN_PUSH) && !full;
	assign do_drop  = ((func_q == FN_POP) && (count_q != '0))
	               || ((func_q == FN_REMOVE) && match);
	assign drop_pos = (func_q == FN_POP) ? '0 : pos_q;

	always_comb begin
		unique case (func_q)
			FN_PUSH:     status_c = full ? ST_FULL : ST_OK;
			FN_POP:      status_c = (count_q == '0) ? ST_EMPTY : ST_OK;
			FN_CONTAINS,
			FN_REMOVE:   status_c = match ? ST_OK : ST_NOT_FOUND;
			default:     status_c = ST_OK;
		endcase
	end

	// Entries above an insert position shift up; those from a removal position on shift down.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_row
		always_ff @(posedge clk) begin
			if (cmd.update && do_ins) begin
				if (CNT_W'(i) == pos_q) begin
					entries_q[i] <= '{cost: cost_q, id: id_q};
				end else if (CNT_W'(i) > pos_q) begin
					if (i > 0) begin
						entries_q[i] <= entries_q[(i > 0) ? i - 1 : 0];
					end
				end
			end else if (cmd.update && do_drop) begin
				if ((CNT_W'(i) >= drop_pos) && (i < CAPACITY - 1)) begin
					entries_q[i] <= entries_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.update) begin
			if (do_ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_drop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Status and match flag of the item.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			status_q <= status_c;
			found_q  <= ((func_q == FN_CONTAINS) || (func_q == FN_REMOVE)) && match;
		end
	end

	// Result register; it frees up when the receiver takes the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.status          <= status_q;
			rsp_q.found           <= found_q;
			rsp_q.top_cost        <= (count_q != '0) ? entries_q[0].cost : '0;
			rsp_q.top_id          <= (count_q != '0) ? entries_q[0].id : '0;
			rsp_q.entry_count_out <= count_q;
			rsp_q.is_empty        <= count_q == '0;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp             = rsp_q;
	assign sts.search_done = done_q;
	assign sts.out_free    = !rsp_valid_q || !rsp_stall;

	// The fill count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// The fill count moves only in the update cycle.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.update |=> $stable(count_q))
		else $error("entry count changed outside an update");

	// The search window stays ordered while it narrows.
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> lo_q <= hi_q)
		else $error("search window inverted");

endmodule

`default_nettype wire

### rtl/sorted_cost_priority_queue.sv
// Top level of the sorted cost priority queue: controller and datapath.
//
// The queue holds up to CAPACITY (cost, id) entries in ascending cost order.
// The req channel carries one item per operation: push, pop lowest, contains
// or remove. The rsp channel returns exactly one item per request, with the
// status, the match flag, the lowest entry and the entry count afterwards.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low.
// One request is worked on at a time. It is latched at the accepting edge,
// then its cost and id are compared against every entry in parallel, the
// search takes one bisection step per cycle over the registered compare flags
// (one step on an empty queue, at most log2(CAPACITY)+1, so 7 for 64
// entries), the controller sees the search end, the entry row is shifted
// and the result register is loaded. The controller returns to idle as the
// result is loaded and then accepts the next request.
// The next request is taken while a result still waits in the result
// register; if the receiver stalls, the following result holds in the
// controller until the register frees up.
// Reset empties the queue and clears the result valid; stored entry contents are
// not cleared and never reach the outputs.
`default_nettype none

module sorted_cost_priority_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire scpq_pkg::req_item_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output scpq_pkg::rsp_item_t      rsp
);
	import scpq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	scpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Entry row, search and result register.
	scpq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
